FILE: rtl/ssps_pkg.sv
// Shared types and constants for the sorted spike pattern store.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ssps_pkg;

  // Sizing
  localparam int MAX_PATTERNS = 64;
  localparam int MAX_SPIKES   = 256;
  localparam int TIME_BITS    = 48;

  localparam int PAT_W  = $clog2(MAX_PATTERNS);     // list number
  localparam int CNT_W  = PAT_W + 1;                // open-list count, 0..MAX_PATTERNS
  localparam int SPK_W  = $clog2(MAX_SPIKES);       // slot within a list
  localparam int LEN_W  = SPK_W + 1;                // list length, 0..MAX_SPIKES
  localparam int ADDR_W = PAT_W + SPK_W;            // record store address
  localparam int ID_W   = 24;                       // layer, group, unit

  // Fixed port widths
  localparam int IDX_PORT_W  = 6;
  localparam int TIME_PORT_W = 48;
  localparam int POS_PORT_W  = 8;
  localparam int LEN_PORT_W  = 9;
  localparam int STAT_W      = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED   = 3'd0,
    ST_OPENED     = 3'd1,
    ST_BEYOND     = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_LIST_FULL  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_SCAN,
    S_PLACE,
    S_RESP
  } seq_state_t;

  // Sequencer to record store control
  typedef struct packed {
    logic              load;      // capture the new record
    logic              wr_en;
    logic              wr_shift;  // 1: move read record up, 0: place new record
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
  } store_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/ssps_rec_store.sv
// Record store: time and id memory, new-record holding register and the
// shared time comparator. Depends on ssps_pkg.
`default_nettype none

module ssps_rec_store
  import ssps_pkg::*;
(
  input  wire logic                 clk,
  input  wire store_ctrl_t          ctrl,
  input  wire logic [TIME_BITS-1:0] key_in,
  input  wire logic [ID_W-1:0]      id_in,
  output logic                      less
);

  logic [TIME_BITS+ID_W-1:0] mem [MAX_SPIKES*MAX_PATTERNS];
  logic [TIME_BITS+ID_W-1:0] rd_q;
  logic [TIME_BITS-1:0]      key;
  logic [ID_W-1:0]           id;
  logic [TIME_BITS+ID_W-1:0] wr_data;

  // New record held for the whole request
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key <= key_in;
      id  <= id_in;
    end
  end

  assign wr_data = ctrl.wr_shift ? rd_q : {key, id};

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
    rd_q <= mem[ctrl.rd_addr];
  end

  // Strictly less: equal times stay ahead of the new spike
  assign less = key < rd_q[TIME_BITS+ID_W-1:ID_W];

endmodule

`default_nettype wire

FILE: rtl/ssps_seq.sv
// Sequencer: pattern count, list length table, insertion scan and result
// registers. Drives the record store through store_ctrl_t. Depends on ssps_pkg.
`default_nettype none

module ssps_seq
  import ssps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [PAT_W-1:0]      pattern_index,
  input  wire logic                  less,
  output store_ctrl_t                ctrl,
  output logic                       busy,
  output logic                       done,
  output status_t                    res_status,
  output logic [SPK_W-1:0]           res_pos,
  output logic [LEN_W-1:0]           res_len
);

  seq_state_t        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [PAT_W-1:0]  idx, idx_next;
  logic [SPK_W-1:0]  pos, pos_next;
  logic [LEN_W-1:0]  new_len, new_len_next;
  logic              opened, opened_next;
  status_t           res_status_next;
  logic [SPK_W-1:0]  res_pos_next;
  logic [LEN_W-1:0]  res_len_next;

  logic [LEN_W-1:0]  len_mem [MAX_PATTERNS];
  logic [LEN_W-1:0]  len_rd;
  logic              len_we;
  logic [CNT_W-1:0]  idx_ext;

  assign idx_ext = {1'b0, pattern_index};

  // Length table, read at the incoming index every cycle
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[idx] <= new_len;
    end
    len_rd <= len_mem[pattern_index];
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pos        <= pos_next;
    new_len    <= new_len_next;
    opened     <= opened_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    res_len    <= res_len_next;
  end

  // Next state and outputs
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    pos_next        = pos;
    new_len_next    = new_len;
    opened_next     = opened;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    res_len_next    = res_len;
    len_we          = 1'b0;
    ctrl            = '0;
    ctrl.wr_addr    = {idx, pos};
    ctrl.rd_addr    = {idx, pos - SPK_W'(2)};

    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load    = 1'b1;
          idx_next     = pattern_index;
          res_pos_next = '0;
          if (idx_ext > count) begin
            res_status_next = ST_BEYOND;
            res_len_next    = '0;
            state_next      = S_RESP;
          end else if (idx_ext == count) begin
            if (count >= CNT_W'(MAX_PATTERNS)) begin
              res_status_next = ST_TABLE_FULL;
              res_len_next    = '0;
              state_next      = S_RESP;
            end else begin
              pos_next     = '0;
              new_len_next = LEN_W'(1);
              opened_next  = 1'b1;
              state_next   = S_PLACE;
            end
          end else begin
            opened_next = 1'b0;
            state_next  = S_LEN;
          end
        end
      end

      // Length arrives from the table; start the scan at the tail
      S_LEN: begin
        if (len_rd >= LEN_W'(MAX_SPIKES)) begin
          res_status_next = ST_LIST_FULL;
          res_len_next    = len_rd;
          state_next      = S_RESP;
        end else begin
          new_len_next = len_rd + LEN_W'(1);
          pos_next     = len_rd[SPK_W-1:0];
          if (len_rd == '0) begin
            state_next = S_PLACE;
          end else begin
            ctrl.rd_addr = {idx, len_rd[SPK_W-1:0] - SPK_W'(1)};
            state_next   = S_SCAN;
          end
        end
      end

      // Record at pos-1 is in the read register; shift it up if later
      S_SCAN: begin
        if (less) begin
          ctrl.wr_en    = 1'b1;
          ctrl.wr_shift = 1'b1;
          pos_next      = pos - SPK_W'(1);
          if (pos == SPK_W'(1)) begin
            state_next = S_PLACE;
          end
        end else begin
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        ctrl.wr_en      = 1'b1;
        len_we          = 1'b1;
        res_status_next = opened ? ST_OPENED : ST_INSERTED;
        res_pos_next    = pos;
        res_len_next    = new_len;
        if (opened) begin
          count_next = count + CNT_W'(1);
        end
        state_next = S_RESP;
      end

      S_RESP: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

endmodule

`default_nettype wire

FILE: rtl/sorted_spike_pattern_store_core.sv
// Sorted spike pattern store, top level.
// Depends on ssps_pkg, ssps_rec_store and ssps_seq.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   carries a pattern index and one spike (time, layer, group, unit).
//   An index equal to the number of open patterns opens a new list holding
//   the spike; a lower index inserts the spike into that list, kept sorted
//   by time, with equal times placed after existing entries.
//   Exactly one result per request: done is high for one cycle while
//   status, insert_position and list_length are valid. The receiver has no
//   way to stall, so it must take the result in that cycle.
//   Steps after the request: an index beyond the count or a full table goes
//   straight to the result; a new pattern writes its record and then gives
//   the result; a lower index reads the list length (a full list then gives
//   the result), scans from the tail, moving each later record up one slot,
//   until slot 0 or a record that stays, then writes the new record and
//   gives the result. The scan moves one record per cycle through the single
//   write and single read port of the record memory. busy stays high until
//   done has been shown and falls in the next cycle, when a new request can
//   be taken; one request at a time.
//   Reset (rst, synchronous) empties the pattern table; record memory and
//   list lengths need no clearing since only written entries are ever used.
`default_nettype none

module sorted_spike_pattern_store_core
  import ssps_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [IDX_PORT_W-1:0]  pattern_index,
  input  wire logic [TIME_PORT_W-1:0] spike_time,
  input  wire logic [7:0]             layer_id,
  input  wire logic [7:0]             group_id,
  input  wire logic [7:0]             unit_id,
  output logic                        busy,
  output logic                        done,
  output logic [STAT_W-1:0]           status,
  output logic [POS_PORT_W-1:0]       insert_position,
  output logic [LEN_PORT_W-1:0]       list_length
);

  store_ctrl_t       ctrl;
  logic              less;
  logic              accept;
  status_t           res_status;
  logic [SPK_W-1:0]  res_pos;
  logic [LEN_W-1:0]  res_len;

  assign accept = start & ~busy;

  ssps_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (accept),
    .pattern_index (pattern_index[PAT_W-1:0]),
    .less          (less),
    .ctrl          (ctrl),
    .busy          (busy),
    .done          (done),
    .res_status    (res_status),
    .res_pos       (res_pos),
    .res_len       (res_len)
  );

  ssps_rec_store u_store (
    .clk    (clk),
    .ctrl   (ctrl),
    .key_in (spike_time[TIME_BITS-1:0]),
    .id_in  ({layer_id, group_id, unit_id}),
    .less   (less)
  );

  // Result ports
  assign status          = res_status;
  assign insert_position = POS_PORT_W'(res_pos);
  assign list_length     = LEN_PORT_W'(res_len);

endmodule

`default_nettype wire

FILE: rtl/ssps_checker.sv
// Port-level checks for the sorted spike pattern store, bound to the top.
// Depends on ssps_pkg and sorted_spike_pattern_store_core.
`default_nettype none

module ssps_checker
  import ssps_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done,
  input wire logic [STAT_W-1:0]     status,
  input wire logic [POS_PORT_W-1:0] insert_position,
  input wire logic [LEN_PORT_W-1:0] list_length
);

  // A taken request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  // A result only ends a request that was taken or in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy && $past(start || busy))
    else $error("done without request in progress");

  // One result per request
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result repeated");

  // Index and table errors report no slot and an empty length
  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_BEYOND || status == ST_TABLE_FULL))
      |-> (insert_position == '0 && list_length == '0))
    else $error("error result carries position or length");

  // A successful insert lands inside the new length
  a_insert_range: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_INSERTED)
      |-> (LEN_PORT_W'(insert_position) < list_length))
    else $error("insert position beyond list length");

endmodule

bind sorted_spike_pattern_store_core ssps_checker u_ssps_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .status          (status),
  .insert_position (insert_position),
  .list_length     (list_length)
);

`default_nettype wire
